FILE: src/lat_pkg.sv
`timescale 1ns / 1ps

package lat_pkg;

  // Fixed field widths of the channels.
  localparam int IN_BITS     = 16;
  localparam int WHOLE_BITS  = 16;
  localparam int HUND_BITS   = 7;
  localparam int DECAY_BITS  = 12;
  localparam int CFG_IDX_BITS = 2;
  localparam int NUM_LANES   = 3;
  localparam int LANE_BITS   = 2;

  // Result item layout: six fields, padded to whole bytes.
  localparam int OUT_FIELD_BITS = 3 * (WHOLE_BITS + HUND_BITS);
  localparam int OUT_BITS       = ((OUT_FIELD_BITS + 7) / 8) * 8;

  // Configuration register indexes.
  localparam logic [CFG_IDX_BITS-1:0] REG_DECAY_SHORT = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_DECAY_MID   = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_DECAY_LONG  = 2'd2;

  // Reset values of the decay registers.
  localparam logic [DECAY_BITS-1:0] DECAY_SHORT_RST = 12'd1884;
  localparam logic [DECAY_BITS-1:0] DECAY_MID_RST   = 12'd2014;
  localparam logic [DECAY_BITS-1:0] DECAY_LONG_RST  = 12'd2037;

  // Lane numbers of the three averages.
  localparam logic [LANE_BITS-1:0] LANE_SHORT = 2'd0;
  localparam logic [LANE_BITS-1:0] LANE_MID   = 2'd1;
  localparam logic [LANE_BITS-1:0] LANE_LONG  = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_STEP,
    ST_STORE,
    ST_FINISH
  } state_t;

  // Commands from the sequencer to the serial multiply-accumulate unit.
  typedef struct packed {
    logic load;
    logic step;
  } mac_cmd_t;

endpackage

FILE: src/lat_mac.sv
`timescale 1ns / 1ps

// Serial multiply-accumulate: avg*decay + scaled*(one - decay), one bit of
// the decay factor per step, followed by the rounding and the fraction shift.
module lat_mac #(
  parameter int STATE_BITS    = 27,
  parameter int FRACTION_BITS = 11
) (
  input  logic                       clk,
  input  lat_pkg::mac_cmd_t          cmd,
  input  logic [STATE_BITS-1:0]      avg_in,
  input  logic [STATE_BITS-1:0]      scaled_in,
  input  logic [FRACTION_BITS:0]     decay_in,
  output logic [STATE_BITS-1:0]      result
);

  localparam int DW = FRACTION_BITS + 1;
  localparam int HW = STATE_BITS + 2;
  localparam int TW = FRACTION_BITS + 2;
  localparam logic [DW-1:0] ONE = DW'(1) << FRACTION_BITS;

  logic [HW-1:0]         acc_hi;
  logic [DW-1:0]         acc_lo;
  logic [DW-1:0]         dec;
  logic [DW-1:0]         comp;
  logic [STATE_BITS-1:0] avg_op;
  logic [STATE_BITS-1:0] scaled_op;
  logic                  round_up;

  logic [HW-1:0] partial;
  logic [TW-1:0] tail;

  assign partial = acc_hi
                 + (dec[0]  ? HW'(avg_op)    : '0)
                 + (comp[0] ? HW'(scaled_op) : '0);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      acc_hi    <= '0;
      acc_lo    <= '0;
      dec       <= decay_in;
      comp      <= ONE - decay_in;
      avg_op    <= avg_in;
      scaled_op <= scaled_in;
      round_up  <= (scaled_in >= avg_in);
    end else if (cmd.step) begin
      acc_hi <= partial >> 1;
      acc_lo <= {partial[0], acc_lo[DW-1:1]};
      dec    <= dec >> 1;
      comp   <= comp >> 1;
    end
  end

  // The full sum is acc_hi * 2^(FB+1) + acc_lo; add the rounding term to the
  // low part and keep the carry into the fraction shift.
  assign tail   = TW'(acc_lo) + (round_up ? TW'(ONE - DW'(1)) : '0);
  assign result = STATE_BITS'((acc_hi << 1) + HW'(tail >> FRACTION_BITS));

endmodule

FILE: src/load_average_tracker.sv
`timescale 1ns / 1ps

// Channel  Direction  Handshake           Payload
// s_*      in         s_tvalid/s_tready   s_tdata: active_tasks
// m_*      out        m_tvalid/m_tready   m_tdata: three averages, whole + hundredths
// cfg_*    in         cfg_valid/cfg_ready cfg_index, cfg_data: decay register writes
//
// The single bit-serial multiply-accumulate unit runs the three averages of
// an item in turn, FRACTION_BITS + 1 steps each plus a load and a store
// state; a new item is taken only in the idle state.
// Reset clears the averages and loads the default decay factors.
// A finished item waits in the output register; the block holds its last
// update cycle while the previous result is still not taken.
module load_average_tracker #(
  parameter int FRACTION_BITS = 11,
  parameter int COUNT_BITS    = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  input  logic [lat_pkg::IN_BITS-1:0]          s_tdata,  // [15:0] active_tasks
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  // [15:0] short_whole, [22:16] short_hundredths, [38:23] mid_whole,
  // [45:39] mid_hundredths, [61:46] long_whole, [68:62] long_hundredths
  output logic [lat_pkg::OUT_BITS-1:0]         m_tdata,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [lat_pkg::CFG_IDX_BITS-1:0]     cfg_index,
  input  logic [lat_pkg::DECAY_BITS-1:0]       cfg_data
);

  localparam int SW  = COUNT_BITS + FRACTION_BITS;
  localparam int DW  = FRACTION_BITS + 1;
  localparam int XW  = (DW > lat_pkg::DECAY_BITS) ? DW : lat_pkg::DECAY_BITS;
  localparam int CXW = (COUNT_BITS > lat_pkg::IN_BITS) ? COUNT_BITS : lat_pkg::IN_BITS;
  localparam int RW  = SW + 1;
  localparam int WW  = (COUNT_BITS + 1 > lat_pkg::WHOLE_BITS) ? COUNT_BITS + 1
                                                              : lat_pkg::WHOLE_BITS + 1;
  localparam int PW  = FRACTION_BITS + lat_pkg::HUND_BITS;
  localparam int CNT_BITS = (DW > 1) ? $clog2(DW) : 1;
  localparam int HALF_STEP = (1 << FRACTION_BITS) / 200;
  localparam logic [CXW-1:0] COUNT_MAX = CXW'((64'd1 << COUNT_BITS) - 64'd1);
  localparam logic [XW-1:0]  ONE_X     = XW'(1) << FRACTION_BITS;
  localparam logic [CNT_BITS-1:0] LAST_STEP = CNT_BITS'(DW - 1);

  typedef struct packed {
    logic [lat_pkg::HUND_BITS-1:0]  hund;
    logic [lat_pkg::WHOLE_BITS-1:0] whole;
  } report_t;

  // Rounds an average to hundredths and splits it into whole and hundredths.
  function automatic report_t report(input logic [SW-1:0] avg);
    logic [RW-1:0] r;
    logic [WW-1:0] w;
    logic [PW-1:0] p;
    report_t       res;
    r = RW'(avg) + RW'(HALF_STEP);
    w = WW'(r >> FRACTION_BITS);
    p = PW'(r[FRACTION_BITS-1:0]) * PW'(100);
    res.whole = (w > WW'({lat_pkg::WHOLE_BITS{1'b1}})) ? {lat_pkg::WHOLE_BITS{1'b1}}
                                                      : lat_pkg::WHOLE_BITS'(w);
    res.hund  = p[PW-1:FRACTION_BITS];
    return res;
  endfunction

  function automatic logic [DW-1:0] clamp_decay(input logic [lat_pkg::DECAY_BITS-1:0] d);
    logic [XW-1:0] dx;
    dx = XW'(d);
    return (dx > ONE_X) ? DW'(ONE_X) : DW'(dx);
  endfunction

  lat_pkg::state_t state;
  lat_pkg::state_t state_next;

  logic [lat_pkg::DECAY_BITS-1:0] decay [lat_pkg::NUM_LANES];
  logic [SW-1:0]                  avg   [lat_pkg::NUM_LANES];
  logic [SW-1:0]                  scaled;
  logic [lat_pkg::LANE_BITS-1:0]  lane;
  logic [CNT_BITS-1:0]            step_cnt;
  logic [lat_pkg::OUT_BITS-1:0]   out_data;

  lat_pkg::mac_cmd_t              mac_cmd;
  logic [SW-1:0]                  mac_result;
  logic                           out_free;
  logic [CXW-1:0]                 count_wide;
  logic [COUNT_BITS-1:0]          count_sat;
  report_t                        rep_short;
  report_t                        rep_mid;
  report_t                        rep_long;

  assign cfg_ready = !rst;
  assign m_tdata   = out_data;
  assign out_free  = !m_tvalid || m_tready;

  assign count_wide = CXW'(s_tdata);
  assign count_sat  = (count_wide > COUNT_MAX) ? COUNT_BITS'(COUNT_MAX)
                                               : COUNT_BITS'(count_wide);

  assign rep_short = report(avg[lat_pkg::LANE_SHORT]);
  assign rep_mid   = report(avg[lat_pkg::LANE_MID]);
  assign rep_long  = report(avg[lat_pkg::LANE_LONG]);

  lat_mac #(
    .STATE_BITS    (SW),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_mac (
    .clk       (clk),
    .cmd       (mac_cmd),
    .avg_in    (avg[lane]),
    .scaled_in (scaled),
    .decay_in  (clamp_decay(decay[lane])),
    .result    (mac_result)
  );

  always_comb begin
    state_next = state;
    case (state)
      lat_pkg::ST_IDLE: begin
        if (s_tvalid) state_next = lat_pkg::ST_LOAD;
      end
      lat_pkg::ST_LOAD:  state_next = lat_pkg::ST_STEP;
      lat_pkg::ST_STEP: begin
        if (step_cnt == LAST_STEP) state_next = lat_pkg::ST_STORE;
      end
      lat_pkg::ST_STORE: begin
        state_next = (lane == lat_pkg::LANE_LONG) ? lat_pkg::ST_FINISH : lat_pkg::ST_LOAD;
      end
      lat_pkg::ST_FINISH: begin
        if (out_free) state_next = lat_pkg::ST_IDLE;
      end
      default: state_next = lat_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready     = 1'b0;
    mac_cmd.load = 1'b0;
    mac_cmd.step = 1'b0;
    case (state)
      lat_pkg::ST_IDLE: s_tready     = !rst;
      lat_pkg::ST_LOAD: mac_cmd.load = 1'b1;
      lat_pkg::ST_STEP: mac_cmd.step = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= lat_pkg::ST_IDLE;
      m_tvalid <= 1'b0;
      lane     <= lat_pkg::LANE_SHORT;
      step_cnt <= '0;
      avg[lat_pkg::LANE_SHORT]   <= '0;
      avg[lat_pkg::LANE_MID]     <= '0;
      avg[lat_pkg::LANE_LONG]    <= '0;
      decay[lat_pkg::LANE_SHORT] <= lat_pkg::DECAY_SHORT_RST;
      decay[lat_pkg::LANE_MID]   <= lat_pkg::DECAY_MID_RST;
      decay[lat_pkg::LANE_LONG]  <= lat_pkg::DECAY_LONG_RST;
    end else begin
      state <= state_next;

      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          lat_pkg::REG_DECAY_SHORT: decay[lat_pkg::LANE_SHORT] <= cfg_data;
          lat_pkg::REG_DECAY_MID:   decay[lat_pkg::LANE_MID]   <= cfg_data;
          lat_pkg::REG_DECAY_LONG:  decay[lat_pkg::LANE_LONG]  <= cfg_data;
          default: ;
        endcase
      end

      if (state == lat_pkg::ST_FINISH && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end

      case (state)
        lat_pkg::ST_IDLE: begin
          lane <= lat_pkg::LANE_SHORT;
        end
        lat_pkg::ST_LOAD: begin
          step_cnt <= '0;
        end
        lat_pkg::ST_STEP: begin
          step_cnt <= step_cnt + CNT_BITS'(1);
        end
        lat_pkg::ST_STORE: begin
          avg[lane] <= mac_result;
          lane      <= lane + lat_pkg::LANE_BITS'(1);
        end
        default: ;
      endcase
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (state == lat_pkg::ST_IDLE && s_tvalid && s_tready) begin
      scaled <= SW'(count_sat) << FRACTION_BITS;
    end
    if (state == lat_pkg::ST_FINISH && out_free) begin
      out_data <= lat_pkg::OUT_BITS'({rep_long.hund, rep_long.whole,
                                      rep_mid.hund, rep_mid.whole,
                                      rep_short.hund, rep_short.whole});
    end
  end

endmodule

FILE: dv/load_average_tracker_test.sv
`timescale 1ns / 1ps

module load_average_tracker_test;

  localparam int FRAC_BITS = 11;
  localparam int AVG_BITS = 27;
  localparam longint unsigned FIXED_ONE = 64'd1 << FRAC_BITS;
  localparam longint unsigned WHOLE_MAX = 64'hFFFF;
  localparam logic [lat_pkg::CFG_IDX_BITS-1:0] REG_UNMAPPED = 2'd3;
  localparam int LANE_FIELD_BITS = lat_pkg::WHOLE_BITS + lat_pkg::HUND_BITS;
  localparam int DRAIN_CYCLES = 80;
  localparam int LONG_HOLD_CYCLES = 800;
  localparam int IDLE_LIMIT = 6000;
  localparam int NUM_PHASES = 9;
  localparam int PHASE_ITEMS = 180;

  typedef struct packed {
    logic [lat_pkg::NUM_LANES-1:0][lat_pkg::WHOLE_BITS-1:0] whole;
    logic [lat_pkg::NUM_LANES-1:0][lat_pkg::HUND_BITS-1:0]  hundredths;
  } load_report_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [lat_pkg::IN_BITS-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [lat_pkg::OUT_BITS-1:0] m_tdata;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [lat_pkg::CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [lat_pkg::DECAY_BITS-1:0] cfg_data = '0;

  load_average_tracker dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  // Predicted block state.
  logic [AVG_BITS-1:0] avg_est[lat_pkg::NUM_LANES];
  logic [lat_pkg::DECAY_BITS-1:0] decay_reg[lat_pkg::NUM_LANES];

  logic [lat_pkg::IN_BITS-1:0] pending_counts[$];
  load_report_t expected_reports[$];
  int queued_items = 0;
  int accepted_items = 0;
  int reported_items = 0;
  int mismatches = 0;
  logic long_stall_req = 1'b0;

  string lane_name[lat_pkg::NUM_LANES] = '{"short", "mid", "long"};

  function automatic logic [AVG_BITS-1:0] decay_next(logic [AVG_BITS-1:0] avg,
                                                     logic [lat_pkg::DECAY_BITS-1:0] decay,
                                                     logic [lat_pkg::IN_BITS-1:0] count);
    longint unsigned scaled, d, sum;
    scaled = longint'(count) << FRAC_BITS;
    d = (decay > FIXED_ONE) ? FIXED_ONE : longint'(decay);
    sum = longint'(avg) * d + scaled * (FIXED_ONE - d);
    // A rising average rounds upward.
    if (scaled >= longint'(avg)) sum += FIXED_ONE - 1;
    sum = sum >> FRAC_BITS;
    return sum[AVG_BITS-1:0];
  endfunction

  function automatic logic [lat_pkg::WHOLE_BITS-1:0] whole_of(logic [AVG_BITS-1:0] avg);
    longint unsigned w;
    w = (longint'(avg) + FIXED_ONE / 200) >> FRAC_BITS;
    if (w > WHOLE_MAX) w = WHOLE_MAX;
    return w[lat_pkg::WHOLE_BITS-1:0];
  endfunction

  function automatic logic [lat_pkg::HUND_BITS-1:0] hundredths_of(logic [AVG_BITS-1:0] avg);
    longint unsigned r;
    r = longint'(avg) + FIXED_ONE / 200;
    r = ((r & (FIXED_ONE - 1)) * 100) >> FRAC_BITS;
    return r[lat_pkg::HUND_BITS-1:0];
  endfunction

  task automatic advance_averages(logic [lat_pkg::IN_BITS-1:0] count);
    load_report_t rep;
    for (int lane = 0; lane < lat_pkg::NUM_LANES; lane++) begin
      avg_est[lane] = decay_next(avg_est[lane], decay_reg[lane], count);
      rep.whole[lane] = whole_of(avg_est[lane]);
      rep.hundredths[lane] = hundredths_of(avg_est[lane]);
    end
    expected_reports.push_back(rep);
  endtask

  task automatic compare_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  // Called at a rising edge; returns at the edge where the write is taken, with
  // cfg_valid still high so that a following write can go out at once.
  task automatic write_decay(logic [lat_pkg::CFG_IDX_BITS-1:0] idx,
                             logic [lat_pkg::DECAY_BITS-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      lat_pkg::REG_DECAY_SHORT: decay_reg[lat_pkg::LANE_SHORT] = value;
      lat_pkg::REG_DECAY_MID:   decay_reg[lat_pkg::LANE_MID] = value;
      lat_pkg::REG_DECAY_LONG:  decay_reg[lat_pkg::LANE_LONG] = value;
      default: ;
    endcase
  endtask

  task automatic configure(logic [lat_pkg::DECAY_BITS-1:0] d_short,
                           logic [lat_pkg::DECAY_BITS-1:0] d_mid,
                           logic [lat_pkg::DECAY_BITS-1:0] d_long, bit touch_unmapped);
    if (touch_unmapped)
      write_decay(REG_UNMAPPED, lat_pkg::DECAY_BITS'($urandom_range(0, 4095)));
    write_decay(lat_pkg::REG_DECAY_SHORT, d_short);
    write_decay(lat_pkg::REG_DECAY_MID, d_mid);
    write_decay(lat_pkg::REG_DECAY_LONG, d_long);
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (!(accepted_items == queued_items && reported_items == accepted_items))
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic queue_count(logic [lat_pkg::IN_BITS-1:0] count);
    pending_counts.push_back(count);
    queued_items++;
  endtask

  function automatic logic [lat_pkg::DECAY_BITS-1:0] pick_decay();
    case ($urandom_range(0, 9))
      0: return 12'd0;
      1: return 12'd2048;
      2: return lat_pkg::DECAY_BITS'($urandom_range(2049, 4095));
      3, 4: return lat_pkg::DECAY_BITS'($urandom_range(0, 4095));
      default: return lat_pkg::DECAY_BITS'($urandom_range(1700, 2047));
    endcase
  endfunction

  function automatic logic [lat_pkg::IN_BITS-1:0] pick_count(logic [lat_pkg::IN_BITS-1:0] prev);
    case ($urandom_range(0, 9))
      0, 1, 2: return lat_pkg::IN_BITS'($urandom_range(0, 16));
      3, 4: return lat_pkg::IN_BITS'($urandom_range(0, 65535));
      5: return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      6: return lat_pkg::IN_BITS'($urandom_range(0, 300));
      // Repeating a count lets the averages settle toward it.
      default: return prev;
    endcase
  endfunction

  initial begin
    logic [lat_pkg::IN_BITS-1:0] prev_count;
    logic [lat_pkg::IN_BITS-1:0] directed[20];
    for (int lane = 0; lane < lat_pkg::NUM_LANES; lane++) avg_est[lane] = '0;
    decay_reg[lat_pkg::LANE_SHORT] = lat_pkg::DECAY_SHORT_RST;
    decay_reg[lat_pkg::LANE_MID] = lat_pkg::DECAY_MID_RST;
    decay_reg[lat_pkg::LANE_LONG] = lat_pkg::DECAY_LONG_RST;
    directed = '{16'd0, 16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd0, 16'd1,
                 16'd2, 16'h8000, 16'hFFFF, 16'h5555, 16'hAAAA, 16'd0, 16'd0, 16'd100,
                 16'd7, 16'hFFFF, 16'd0, 16'h8001};
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Reset decay factors first, then a series of register settings.
    foreach (directed[i]) queue_count(directed[i]);
    wait_drained();
    prev_count = '0;
    for (int phase = 1; phase <= NUM_PHASES; phase++) begin
      case (phase)
        1: configure(12'd0, 12'd0, 12'd0, 1'b0);
        2: configure(12'd2048, 12'd2048, 12'd2048, 1'b1);
        3: configure(12'd4095, 12'd4095, 12'd4095, 1'b0);
        4: configure(12'd1, 12'd2047, 12'd2049, 1'b0);
        NUM_PHASES: configure(lat_pkg::DECAY_SHORT_RST, lat_pkg::DECAY_MID_RST,
                              lat_pkg::DECAY_LONG_RST, 1'b1);
        default: configure(pick_decay(), pick_decay(), pick_decay(), 1'b0);
      endcase
      // Keep the receiver back for a while so the block backs up its input.
      if (phase == 3) long_stall_req = 1'b1;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        prev_count = pick_count(prev_count);
        queue_count(prev_count);
      end
      wait_drained();
    end

    if (expected_reports.size() != 0) begin
      $error("%0d results never arrived", expected_reports.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  int burst_left = 0;
  int gap_left = 0;

  always @(posedge clk) begin : drive
    logic next_valid;
    logic [lat_pkg::IN_BITS-1:0] next_data;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      next_valid = s_tvalid;
      next_data = s_tdata;
      if (s_tvalid && s_tready) begin
        accepted_items++;
        advance_averages(s_tdata);
        next_valid = 1'b0;
      end
      if (!next_valid) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_counts.size() > 0) begin
          next_valid = 1'b1;
          next_data = pending_counts.pop_front();
          if (burst_left == 0) begin
            case ($urandom_range(0, 3))
              0: begin
                burst_left = 60;
                gap_left = 0;
              end
              1: begin
                burst_left = $urandom_range(1, 20);
                gap_left = $urandom_range(46, 120);
              end
              default: begin
                burst_left = $urandom_range(1, 20);
                gap_left = $urandom_range(0, 45);
              end
            endcase
          end else begin
            burst_left--;
          end
        end
      end
      s_tvalid <= next_valid;
      s_tdata <= next_data;
    end
  end

  int ready_mode = 0;
  int mode_left = 0;
  int hold_count = 0;
  logic long_stall_done = 1'b0;

  always @(posedge clk) begin : observe
    logic ready_next;
    load_report_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        reported_items++;
        if (expected_reports.size() == 0) begin
          $error("result arrived with nothing expected");
          mismatches++;
        end else begin
          want = expected_reports.pop_front();
          for (int lane = 0; lane < lat_pkg::NUM_LANES; lane++) begin
            compare_field({lane_name[lane], "_whole"}, 32'(want.whole[lane]),
                          32'(m_tdata[lane*LANE_FIELD_BITS +: lat_pkg::WHOLE_BITS]));
            compare_field({lane_name[lane], "_hundredths"}, 32'(want.hundredths[lane]),
                          32'(m_tdata[lane*LANE_FIELD_BITS + lat_pkg::WHOLE_BITS
                                      +: lat_pkg::HUND_BITS]));
          end
        end
      end
      if (long_stall_req && !long_stall_done) begin
        if (hold_count < LONG_HOLD_CYCLES) begin
          hold_count++;
          ready_next = 1'b0;
        end else begin
          long_stall_done = 1'b1;
          ready_next = 1'b1;
        end
      end else begin
        if (mode_left == 0) begin
          ready_mode = $urandom_range(0, 3);
          mode_left = $urandom_range(20, 300);
        end
        mode_left--;
        case (ready_mode)
          0: ready_next = 1'b1;
          1: ready_next = 1'($urandom_range(0, 1));
          2: ready_next = ($urandom_range(0, 3) == 0);
          default: ready_next = ($urandom_range(0, 15) == 0);
        endcase
      end
      m_tready <= ready_next;
    end
  end

  int idle_cycles = 0;

  always @(posedge clk) begin
    if (!rst) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

endmodule
